@@ sv/barrier_slack_reciprocal_defines.svh @@
// Assertion macros for the barrier slack reciprocal block
`ifndef BARRIER_SLACK_RECIPROCAL_DEFINES_SVH
`define BARRIER_SLACK_RECIPROCAL_DEFINES_SVH
// Implication checked on every clock edge outside reset
`define BSR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset
`define BSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ sv/bsr_pkg.sv @@
// Package: types, constants and helpers for the barrier slack reciprocal block
package bsr_pkg;
    localparam int DataWidth = 32;
    localparam int FracBits  = 16;
    localparam int RecipWidth = DataWidth - 1;
    localparam int QuotBits  = 2 * FracBits + 1;
    localparam int AddrWidth = 1;

    localparam logic [1:0] KIND_BOTH  = 2'd0;
    localparam logic [1:0] KIND_LOWER = 2'd1;
    localparam logic [1:0] KIND_UPPER = 2'd2;
    localparam logic [1:0] KIND_FREE  = 2'd3;

    localparam logic [AddrWidth-1:0] REG_MIN_SLACK = 1'b0;

    typedef struct packed {
        logic [1:0]                  bound_kind;
        logic signed [DataWidth-1:0] cost_coef;
        logic signed [DataWidth-1:0] value;
        logic signed [DataWidth-1:0] lower_bound;
        logic signed [DataWidth-1:0] upper_bound;
        logic                        last_in;
    } t_in_item;

    typedef struct packed {
        logic signed [DataWidth-1:0] doubled_cost;
        logic signed [DataWidth-1:0] low_slack;
        logic signed [DataWidth-1:0] high_slack;
        logic [RecipWidth-1:0]       inv_low_slack;
        logic [RecipWidth-1:0]       inv_high_slack;
        logic                        last_out;
    } t_out_item;

    // Side data carried along the divider pipelines
    typedef struct packed {
        logic signed [DataWidth-1:0] doubled_cost;
        logic signed [DataWidth-1:0] low_slack;
        logic signed [DataWidth-1:0] high_slack;
        logic                        has_low;
        logic                        has_high;
        logic                        last;
    } t_side;

    // Saturating subtraction a - b
    function automatic logic signed [DataWidth-1:0] sat_sub(
        input logic signed [DataWidth-1:0] a, input logic signed [DataWidth-1:0] b);
        logic signed [DataWidth:0] d;
        begin
            d = {a[DataWidth-1], a} - {b[DataWidth-1], b};
            if (d[DataWidth] != d[DataWidth-1])
                sat_sub = d[DataWidth] ? {1'b1, {(DataWidth-1){1'b0}}}
                                       : {1'b0, {(DataWidth-1){1'b1}}};
            else
                sat_sub = d[DataWidth-1:0];
        end
    endfunction
endpackage

@@ sv/bsr_divider.sv @@
// Pipelined restoring divider: 2^(2*FracBits) / divisor, one quotient bit per stage
`include "barrier_slack_reciprocal_defines.svh"
module bsr_divider (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_advance,
    input  logic [bsr_pkg::DataWidth-1:0]       i_divisor,
    output logic [bsr_pkg::RecipWidth-1:0]      o_quotient
);
    localparam int N  = bsr_pkg::QuotBits;
    localparam int DW = bsr_pkg::DataWidth;

    // Stage s holds remainder, divisor, quotient so far and saturation flag
    logic [DW:0]   r_rem [N];
    logic [DW-1:0] r_div [N];
    logic [N-1:0]  r_quo [N];
    logic          r_sat [N];

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            for (int s = 0; s < N; s++) begin
                logic [DW:0]   rem_in;
                logic [DW-1:0] div_in;
                logic [N-1:0]  quo_in;
                logic          sat_in;
                logic [DW+1:0] trial;
                logic [DW:0]   rem_sh;
                logic [N-1:0]  quo_new;
                if (s == 0) begin
                    rem_in = '0;
                    div_in = i_divisor;
                    quo_in = '0;
                    sat_in = (i_divisor == '0);
                end else begin
                    rem_in = r_rem[s-1];
                    div_in = r_div[s-1];
                    quo_in = r_quo[s-1];
                    sat_in = r_sat[s-1];
                end
                // shift in the single one bit of the dividend at the top step
                rem_sh = {rem_in[DW-1:0], (s == 0) ? 1'b1 : 1'b0};
                trial = {1'b0, rem_sh} - {2'b00, div_in};
                quo_new = {quo_in[N-2:0], ~trial[DW+1]};
                r_rem[s] <= trial[DW+1] ? rem_sh : trial[DW:0];
                r_div[s] <= div_in;
                r_quo[s] <= quo_new;
                r_sat[s] <= sat_in;
            end
        end
    end

    always_comb begin
        if (r_sat[N-1] || r_quo[N-1][N-1:bsr_pkg::RecipWidth] != '0)
            o_quotient = '1;
        else
            o_quotient = r_quo[N-1][bsr_pkg::RecipWidth-1:0];
    end

    `BSR_ASSERT_NEXT(a_div_zero_sat, i_clk, i_rst_n,
        i_advance && i_divisor == '0, r_sat[0])
    `BSR_ASSERT_NEXT(a_div_hold, i_clk, i_rst_n,
        !i_advance, $stable(o_quotient))
    `BSR_ASSERT_IMP(a_div_sat_out, i_clk, i_rst_n,
        r_sat[N-1], o_quotient == '1)
endmodule

@@ sv/bsr_front.sv @@
// Front stage: saturated slacks, doubled cost and clamped divisors
module bsr_front (
    input  logic                           i_clk,
    input  logic                           i_advance,
    input  bsr_pkg::t_in_item              i_item,
    input  logic [30:0]                    i_min_slack,
    output bsr_pkg::t_side                 o_side,
    output logic [bsr_pkg::DataWidth-1:0]  o_low_div,
    output logic [bsr_pkg::DataWidth-1:0]  o_high_div
);
    localparam int DW = bsr_pkg::DataWidth;
    bsr_pkg::t_side r_side;
    logic [DW-1:0] r_low_div, r_high_div;
    bsr_pkg::t_side n_side;
    logic signed [DW-1:0] ls, hs;
    logic signed [DW:0] ms;

    function automatic logic [DW-1:0] clamp(input logic signed [DW-1:0] s,
                                            input logic signed [DW:0] m);
        begin
            if ($signed({s[DW-1], s}) < m) clamp = m[DW-1:0];
            else clamp = s;
        end
    endfunction

    always_comb begin
        ms = $signed({2'b00, i_min_slack});
        ls = bsr_pkg::sat_sub(i_item.value, i_item.lower_bound);
        hs = bsr_pkg::sat_sub(i_item.upper_bound, i_item.value);
        n_side.has_low  = (i_item.bound_kind == bsr_pkg::KIND_BOTH) ||
                          (i_item.bound_kind == bsr_pkg::KIND_LOWER);
        n_side.has_high = (i_item.bound_kind == bsr_pkg::KIND_BOTH) ||
                          (i_item.bound_kind == bsr_pkg::KIND_UPPER);
        n_side.low_slack  = n_side.has_low ? ls : '0;
        n_side.high_slack = n_side.has_high ? hs : '0;
        if (i_item.cost_coef[DW-1] != i_item.cost_coef[DW-2])
            n_side.doubled_cost = i_item.cost_coef[DW-1] ? {1'b1, {(DW-1){1'b0}}}
                                                         : {1'b0, {(DW-1){1'b1}}};
        else
            n_side.doubled_cost = {i_item.cost_coef[DW-2:0], 1'b0};
        n_side.last = i_item.last_in;
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_side     <= n_side;
            r_low_div  <= clamp(ls, ms);
            r_high_div <= clamp(hs, ms);
        end
    end

    assign o_side = r_side;
    assign o_low_div = r_low_div;
    assign o_high_div = r_high_div;
endmodule

@@ sv/barrier_slack_reciprocal.sv @@
// Barrier slack reciprocal: top level with register port and stalled pipeline
// One variable enters per cycle unless the pipeline holds; each result passes one front stage,
// 33 restoring-divider stages of one quotient bit each and one output register. The whole
// pipeline advances together and holds in place while the output is stalled and full.
`include "barrier_slack_reciprocal_defines.svh"
module barrier_slack_reciprocal (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bsr_pkg::AddrWidth+1:0]      paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  bsr_pkg::t_in_item                  i_item,
    output logic                               o_valid,
    input  logic                               i_stall,
    output bsr_pkg::t_out_item                 o_item
);
    localparam int Depth = bsr_pkg::QuotBits + 1;
    localparam int DW = bsr_pkg::DataWidth;

    logic [30:0] r_min_slack;
    logic [Depth-1:0] r_vld;
    bsr_pkg::t_side r_side [bsr_pkg::QuotBits];
    logic r_out_vld;
    bsr_pkg::t_out_item r_out;
    logic advance;
    bsr_pkg::t_side front_side;
    logic [DW-1:0] low_div, high_div;
    logic [bsr_pkg::RecipWidth-1:0] low_q, high_q;

    assign pready = 1'b1;
    assign prdata = (paddr[bsr_pkg::AddrWidth+1:2] == bsr_pkg::REG_MIN_SLACK)
                    ? {1'b0, r_min_slack} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_min_slack <= 31'd1;
        else if (psel && penable && pwrite &&
                 paddr[bsr_pkg::AddrWidth+1:2] == bsr_pkg::REG_MIN_SLACK)
            r_min_slack <= pwdata[30:0];
    end

    // Whole pipe moves when output slot is free or will be emptied
    assign advance = !r_out_vld || !i_stall;
    assign o_stall = !advance;

    bsr_front u_front (
        .i_clk(i_clk), .i_advance(advance), .i_item(i_item),
        .i_min_slack(r_min_slack), .o_side(front_side),
        .o_low_div(low_div), .o_high_div(high_div));

    bsr_divider u_div_low (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_advance(advance),
        .i_divisor(low_div), .o_quotient(low_q));
    bsr_divider u_div_high (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_advance(advance),
        .i_divisor(high_div), .o_quotient(high_q));

    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int s = 0; s < bsr_pkg::QuotBits; s++)
                r_side[s] <= (s == 0) ? front_side : r_side[(s == 0) ? 0 : s-1];
            r_out.doubled_cost   <= r_side[bsr_pkg::QuotBits-1].doubled_cost;
            r_out.low_slack      <= r_side[bsr_pkg::QuotBits-1].low_slack;
            r_out.high_slack     <= r_side[bsr_pkg::QuotBits-1].high_slack;
            r_out.inv_low_slack  <= r_side[bsr_pkg::QuotBits-1].has_low ? low_q : '0;
            r_out.inv_high_slack <= r_side[bsr_pkg::QuotBits-1].has_high ? high_q : '0;
            r_out.last_out       <= r_side[bsr_pkg::QuotBits-1].last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_vld <= {r_vld[Depth-2:0], i_valid};
            r_out_vld <= r_vld[Depth-1];
        end
    end

    assign o_valid = r_out_vld;
    assign o_item = r_out;

    `BSR_ASSERT_IMP(a_stall_only_full, i_clk, i_rst_n, o_stall, r_out_vld && i_stall)
    `BSR_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `BSR_ASSERT_NEXT(a_hold_item, i_clk, i_rst_n, o_valid && i_stall, $stable(o_item))
endmodule

@@ tb/bsr_checker.sv @@
// Checker: predicts each transaction of the slack block and compares its results
`timescale 1ns / 100ps
module bsr_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [30:0]           i_cfg_min_slack,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  bsr_pkg::t_in_item     i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  bsr_pkg::t_out_item    i_out_item,
    output int                    o_errors,
    output int                    o_pending
);
    localparam longint QMax = 64'sd2147483647;
    localparam longint QMin = -64'sd2147483648;

    logic [30:0]        min_slack_q;
    bsr_pkg::t_out_item expected_q[$];

    function automatic longint clamp_q(input longint x);
        if (x > QMax) return QMax;
        if (x < QMin) return QMin;
        return x;
    endfunction

    // 2^32 / max(slack, min_slack), truncated and saturated
    function automatic logic [30:0] reciprocal(input longint slack, input logic [30:0] floor_v);
        longint d;
        longint unsigned q;
        d = slack;
        if (d < longint'(floor_v)) d = longint'(floor_v);
        if (d <= 0) return 31'h7fffffff;
        q = (64'd1 << 32) / longint'(d);
        if (q > 64'd2147483647) return 31'h7fffffff;
        return q[30:0];
    endfunction

    function automatic bsr_pkg::t_out_item predict_slacks(input bsr_pkg::t_in_item it,
                                                          input logic [30:0] floor_v);
        bsr_pkg::t_out_item r;
        longint             s;
        logic               has_lo, has_hi;
        has_lo = (it.bound_kind == bsr_pkg::KIND_BOTH) || (it.bound_kind == bsr_pkg::KIND_LOWER);
        has_hi = (it.bound_kind == bsr_pkg::KIND_BOTH) || (it.bound_kind == bsr_pkg::KIND_UPPER);
        r = '0;
        r.doubled_cost = 32'(clamp_q(2 * longint'(it.cost_coef)));
        if (has_lo) begin
            s = clamp_q(longint'(it.value) - longint'(it.lower_bound));
            r.low_slack = 32'(s);
            r.inv_low_slack = reciprocal(s, floor_v);
        end
        if (has_hi) begin
            s = clamp_q(longint'(it.upper_bound) - longint'(it.value));
            r.high_slack = 32'(s);
            r.inv_high_slack = reciprocal(s, floor_v);
        end
        r.last_out = it.last_in;
        return r;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        bsr_pkg::t_out_item exp_r;
        if (!i_rst_n) begin
            min_slack_q <= 31'd1;
            o_errors <= 0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) min_slack_q <= i_cfg_min_slack;
            if (i_in_valid && !i_in_stall)
                expected_q.push_back(predict_slacks(i_in_item, min_slack_q));
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_out_item);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (exp_r !== i_out_item) begin
                        $display("%0t: mismatch expected %h actual %h", $time, exp_r,
                                 i_out_item);
                        $display("  cost %h/%h lo %h/%h hi %h/%h il %h/%h ih %h/%h last %b/%b",
                                 exp_r.doubled_cost, i_out_item.doubled_cost,
                                 exp_r.low_slack, i_out_item.low_slack,
                                 exp_r.high_slack, i_out_item.high_slack,
                                 exp_r.inv_low_slack, i_out_item.inv_low_slack,
                                 exp_r.inv_high_slack, i_out_item.inv_high_slack,
                                 exp_r.last_out, i_out_item.last_out);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

@@ tb/tb.sv @@
// Testbench top: stimulus, register writes and verdict for the slack block
`timescale 1ns / 100ps
module tb;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [bsr_pkg::AddrWidth+1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_stall;
    bsr_pkg::t_in_item i_item = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    bsr_pkg::t_out_item o_item;
    int errors, pending;
    bit quiet = 1'b0;
    bit hold_off = 1'b0;

    always #4 i_clk = ~i_clk;

    barrier_slack_reciprocal i_dut (.*);

    bsr_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(psel && penable && pwrite && pready &&
                  paddr == {bsr_pkg::REG_MIN_SLACK, 2'b00}),
        .i_cfg_min_slack(pwdata[30:0]),
        .i_in_valid(i_valid), .i_in_stall(o_stall), .i_in_item(i_item),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_out_item(o_item),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        #2_000_000;
        $display("barrier_slack_reciprocal verification failed");
        $finish;
    end

    // Receiver stalls: random bursts, plus a long hold-off on request
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_stall <= 1'b1;
                repeat (120) @(negedge i_clk);
                hold_off = 1'b0;
                i_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 19);
                i_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic write_min_slack(input logic [30:0] v);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {bsr_pkg::REG_MIN_SLACK, 2'b00};
        pwdata <= {1'b0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain_pipeline();
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_q(input int mode);
        case (mode)
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 8) - 4;
            3: return $urandom_range(0, 32'h3ffff);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input bsr_pkg::t_in_item it, input bit gaps);
        int n;
        if (gaps && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 19);
            i_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        i_item <= it;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int count, input bit gaps);
        bsr_pkg::t_in_item it;
        int mode;
        repeat (count) begin
            mode = $urandom_range(0, 9);
            it.bound_kind = 2'($urandom_range(0, 3));
            it.cost_coef = rand_q(mode < 2 ? mode : 4);
            it.value = rand_q($urandom_range(0, 4));
            if ($urandom_range(0, 1)) begin
                // Near-bound slacks exercise the clamp and large reciprocals
                it.lower_bound = it.value - rand_q($urandom_range(2, 3));
                it.upper_bound = it.value + rand_q($urandom_range(2, 3));
            end else begin
                it.lower_bound = rand_q($urandom_range(0, 4));
                it.upper_bound = rand_q($urandom_range(0, 4));
            end
            it.last_in = 1'($urandom_range(0, 1));
            send_item(it, gaps);
        end
        i_valid <= 1'b0;
    endtask

    initial begin
        bsr_pkg::t_in_item it;
        logic [30:0] settings[5] = '{31'd1, 31'h7fffffff, 31'd0, 31'h10000, 31'd300};
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: each bound kind against the edges of the number range
        for (int k = 0; k < 4; k++) begin
            it = '{bound_kind: 2'(k), cost_coef: 32'h7fffffff, value: 32'h7fffffff,
                   lower_bound: 32'h80000000, upper_bound: 32'h80000000, last_in: 1'b0};
            send_item(it, 1'b0);
            it = '{bound_kind: 2'(k), cost_coef: 32'h80000000, value: 32'h80000000,
                   lower_bound: 32'h7fffffff, upper_bound: 32'h7fffffff, last_in: 1'b1};
            send_item(it, 1'b0);
            it = '{bound_kind: 2'(k), cost_coef: 32'h1, value: 32'h10000,
                   lower_bound: 32'h0, upper_bound: 32'h20000, last_in: 1'b0};
            send_item(it, 1'b0);
            it = '{bound_kind: 2'(k), cost_coef: 32'hffffffff, value: 32'h5,
                   lower_bound: 32'h5, upper_bound: 32'h6, last_in: 1'b1};
            send_item(it, 1'b0);
        end
        i_valid <= 1'b0;
        drain_pipeline();

        foreach (settings[s]) begin
            write_min_slack(settings[s]);
            if (s == 1) hold_off = 1'b1;
            send_random(140, 1'b1);
            drain_pipeline();
        end
        write_min_slack(31'd1);
        quiet = 1'b1;
        send_random(60, 1'b0);
        drain_pipeline();

        if (errors == 0)
            $display("barrier_slack_reciprocal verification clean");
        else
            $display("barrier_slack_reciprocal verification failed");
        $finish;
    end
endmodule
